### hdl/stre_pkg.sv
package stre_pkg;

  typedef enum logic [1:0] {
    OP_LOAD_CORE   = 2'd0,
    OP_LOAD_FACTOR = 2'd1,
    OP_EVALUATE    = 2'd2,
    OP_CLEAR       = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_MUL,
    ST_DIFF,
    ST_SQ,
    ST_ACC,
    ST_OUT
  } state_t;

  localparam logic [0:0] REG_TENSOR_ORDER = 1'b0;
  localparam logic [0:0] REG_CORE_COUNT   = 1'b1;

  localparam logic signed [63:0] S32_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] S32_MIN = -64'sh0000_0000_8000_0000;

  // round half up to q16.16 and saturate to 32 bits signed
  function automatic logic signed [31:0] round_sat(input logic signed [63:0] p);
    logic signed [63:0] t;
    begin
      t = (p + 64'sd32768) >>> 16;
      if (t > S32_MAX) round_sat = 32'sh7FFF_FFFF;
      else if (t < S32_MIN) round_sat = 32'sh8000_0000;
      else round_sat = t[31:0];
    end
  endfunction

endpackage

### hdl/sparse_tucker_reconstruct_error.sv
// Sparse Tucker reconstruction error evaluator. Load-core, load-factor and
// clear items give no result. An evaluate item walks the first core_count
// core slots; each slot issues one factor read per mode in use from the
// single-port factor memory and multiplies in one stage each, through the
// shared 32x32 multiplier. Results leave through an output register, and the
// next item is taken once the result is handed over.
module sparse_tucker_reconstruct_error #(
  parameter int MAX_ORDER  = 4,
  parameter int MAX_ROWS   = 1024,
  parameter int RANK       = 16,
  parameter int CORE_DEPTH = 1024
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [0:0]   cfg_index,
  input  logic [10:0]  cfg_data,
  input  logic         s_tvalid,
  output logic         s_tready,
  // operation[1:0] mode_sel[3:2] factor_row[13:4] factor_col[17:14] core_slot[27:18]
  // coord_0[37:28] coord_1[47:38] coord_2[57:48] coord_3[67:58] value[99:68]
  input  logic [103:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // predicted[31:0] sq_error[79:32] error_sum[135:80] norm_sum[191:136]
  // entry_count[223:192]
  output logic [223:0] m_tdata
);
  import stre_pkg::*;

  localparam int MW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
  localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int KW = (RANK > 1) ? $clog2(RANK) : 1;
  localparam int CW = (CORE_DEPTH > 1) ? $clog2(CORE_DEPTH) : 1;
  localparam int FDEPTH = MAX_ORDER * MAX_ROWS * RANK;
  localparam int FAW = $clog2(FDEPTH);
  localparam int NC = 4;
  localparam logic [55:0] SUM_MAX = {56{1'b1}};
  localparam logic [47:0] SQ_MAX = {48{1'b1}};

  // input fields
  logic [1:0]  in_op;
  logic [1:0]  in_mode;
  logic [9:0]  in_frow;
  logic [3:0]  in_fcol;
  logic [9:0]  in_slot;
  logic [9:0]  in_coord [NC];
  logic signed [31:0] in_value;
  assign in_op    = s_tdata[1:0];
  assign in_mode  = s_tdata[3:2];
  assign in_frow  = s_tdata[13:4];
  assign in_fcol  = s_tdata[17:14];
  assign in_slot  = s_tdata[27:18];
  assign in_coord[0] = s_tdata[37:28];
  assign in_coord[1] = s_tdata[47:38];
  assign in_coord[2] = s_tdata[57:48];
  assign in_coord[3] = s_tdata[67:58];
  assign in_value = s_tdata[99:68];

  // config
  logic [2:0]  tensor_order;
  logic [10:0] core_count;
  always_ff @(posedge clk) begin
    if (rst) begin
      tensor_order <= 3'd3;
      core_count   <= 11'd0;
    end else if (cfg_we) begin
      if (cfg_index == REG_TENSOR_ORDER) tensor_order <= cfg_data[2:0];
      else core_count <= cfg_data;
    end
  end

  logic [3:0]  order_eff;
  logic [16:0] count_eff;
  always_comb begin
    if (tensor_order == 3'd0) order_eff = 4'd1;
    else if (32'(tensor_order) > MAX_ORDER) order_eff = 4'(MAX_ORDER);
    else order_eff = {1'b0, tensor_order};
    if (32'(core_count) > CORE_DEPTH) count_eff = 17'(CORE_DEPTH);
    else count_eff = {6'd0, core_count};
  end

  // memories
  logic [31:0]           core_val_mem [CORE_DEPTH];
  logic [MAX_ORDER*KW-1:0] core_idx_mem [CORE_DEPTH];
  logic [31:0]           factor_mem   [FDEPTH];

  logic                  s_fire, m_fire;
  assign s_fire = s_tvalid && s_tready;
  assign m_fire = m_tvalid && m_tready;

  state_t state, state_next;
  logic [16:0] slot_cnt;
  logic [3:0]  mode_cnt;
  logic [9:0]  ecoord [MAX_ORDER];
  logic signed [31:0] obs;
  logic signed [31:0] term;
  logic signed [43:0] sum;
  logic [31:0] cval_q;
  logic [MAX_ORDER*KW-1:0] cidx_q;
  logic [31:0] fval_q;
  logic        frow_ok;
  logic signed [63:0] prod;
  logic signed [31:0] pred;
  logic signed [32:0] diff;
  logic [31:0] diff_mag, obs_mag;
  logic [63:0] sq_raw, nsq_raw;
  logic [55:0] err_acc, norm_acc;
  logic [31:0] count_acc;
  logic [47:0] sq_q;

  // core index write packing
  logic [MAX_ORDER*KW-1:0] idx_wr;
  always_comb begin
    for (int i = 0; i < MAX_ORDER; i++) begin
      idx_wr[i*KW +: KW] = (i < NC) ? KW'(32'(in_coord[i]) % RANK) : '0;
    end
  end

  // core table write and read
  logic [CW-1:0] core_raddr;
  assign core_raddr = slot_cnt[CW-1:0];
  always_ff @(posedge clk) begin
    if (s_fire && in_op == OP_LOAD_CORE && 32'(in_slot) < CORE_DEPTH) begin
      core_val_mem[in_slot[CW-1:0]] <= in_value;
      core_idx_mem[in_slot[CW-1:0]] <= idx_wr;
    end
    cval_q <= core_val_mem[core_raddr];
    cidx_q <= core_idx_mem[core_raddr];
  end

  // factor memory, one port
  logic [MW-1:0] cur_mode;
  logic [9:0]    cur_row;
  logic [KW-1:0] cur_col;
  logic [FAW-1:0] f_raddr, f_waddr;
  logic           f_we;
  assign cur_mode = mode_cnt[MW:1];
  assign cur_row  = ecoord[cur_mode];
  assign cur_col  = cidx_q[cur_mode*KW +: KW];
  assign f_raddr  = FAW'((32'(cur_mode) * MAX_ROWS + 32'(cur_row)) * RANK + 32'(cur_col));
  assign f_waddr  = FAW'((32'(in_mode) * MAX_ROWS + 32'(in_frow)) * RANK + 32'(in_fcol));
  assign f_we = s_fire && in_op == OP_LOAD_FACTOR && 32'(in_mode) < MAX_ORDER
                && 32'(in_frow) < MAX_ROWS && 32'(in_fcol) < RANK;
  always_ff @(posedge clk) begin
    if (f_we) factor_mem[f_waddr] <= in_value;
    else fval_q <= factor_mem[f_raddr];
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (s_fire && in_op == OP_EVALUATE) begin
        state_next = (count_eff == 17'd0) ? ST_DIFF : ST_READ;
      end
      ST_READ: state_next = ST_MUL;
      ST_MUL: begin
        if (mode_cnt[0]) begin
          if (mode_cnt[3:1] + 3'd1 == order_eff[2:0] || mode_cnt[3:1] + 4'd1 == order_eff)
            state_next = (slot_cnt + 17'd1 == count_eff) ? ST_DIFF : ST_READ;
        end
      end
      ST_DIFF: state_next = ST_SQ;
      ST_SQ:   state_next = ST_ACC;
      ST_ACC:  state_next = ST_OUT;
      ST_OUT:  if (m_fire) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  assign s_tready = (state == ST_IDLE) && !m_tvalid;

  // mode_cnt: bits [3:1] mode, bit 0 phase (0 read issue, 1 multiply)
  logic [MW-1:0] mul_mode;
  assign mul_mode = mode_cnt[MW:1];
  assign frow_ok = 32'(ecoord[mul_mode]) < MAX_ROWS;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      err_acc   <= '0;
      norm_acc  <= '0;
      count_acc <= '0;
      m_tvalid  <= 1'b0;
      slot_cnt  <= '0;
      mode_cnt  <= '0;
    end else begin
      state <= state_next;
      if (m_fire) m_tvalid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (s_fire && in_op == OP_CLEAR) begin
            err_acc <= '0; norm_acc <= '0; count_acc <= '0;
          end
          if (s_fire && in_op == OP_EVALUATE) begin
            for (int i = 0; i < MAX_ORDER; i++) ecoord[i] <= (i < NC) ? in_coord[i] : '0;
            obs <= in_value;
            sum <= '0;
            slot_cnt <= '0;
            mode_cnt <= '0;
          end
        end
        ST_READ: begin
          mode_cnt <= '0;
        end
        ST_MUL: begin
          if (!mode_cnt[0]) begin
            if (mode_cnt == 4'd0) term <= cval_q;
          end else begin
            term <= round_sat(prod);
          end
          if (mode_cnt[0] && state_next != ST_MUL) begin
            sum <= sum + 44'(round_sat(prod));
            slot_cnt <= slot_cnt + 17'd1;
          end
          mode_cnt <= mode_cnt + 4'd1;
        end
        ST_DIFF: begin
          if (sum > 44'(S32_MAX)) pred <= 32'sh7FFF_FFFF;
          else if (sum < 44'(S32_MIN)) pred <= 32'sh8000_0000;
          else pred <= sum[31:0];
        end
        ST_SQ: begin
          sq_raw  <= ({32'd0, diff_mag} * {32'd0, diff_mag}) + 64'd32768;
          nsq_raw <= ({32'd0, obs_mag} * {32'd0, obs_mag}) + 64'd32768;
        end
        ST_ACC: begin
          sq_q <= ((sq_raw >> 16) > 64'(SQ_MAX)) ? SQ_MAX : 48'(sq_raw >> 16);
          begin
            logic [56:0] es, ns;
            logic [47:0] sqv;
            sqv = ((sq_raw >> 16) > 64'(SQ_MAX)) ? SQ_MAX : 48'(sq_raw >> 16);
            es = 57'(err_acc) + 57'(sqv);
            ns = 57'(norm_acc) + 57'(nsq_raw >> 16);
            err_acc  <= es[56] ? SUM_MAX : es[55:0];
            norm_acc <= ns[56] ? SUM_MAX : ns[55:0];
          end
          if (count_acc != 32'hFFFF_FFFF) count_acc <= count_acc + 32'd1;
          m_tvalid <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // shared multiplier: term times factor element of the current mode
  logic signed [31:0] mul_a;
  assign mul_a = (mode_cnt[3:1] == 3'd0) ? $signed(cval_q) : term;
  assign prod  = 64'(mul_a) * 64'(frow_ok ? $signed(fval_q) : 32'sd0);
  assign diff  = 33'(obs) - 33'(pred);

  // magnitudes for the squares, both fit in 32 bits unsigned
  assign diff_mag = (diff < 0) ? 32'(-diff) : 32'(diff);
  assign obs_mag  = (obs < 0) ? 32'(-33'(obs)) : 32'(obs);

  assign m_tdata = {count_acc, norm_acc, err_acc, sq_q, pred};

  // checks
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> state == ST_IDLE) else $error("ready outside idle");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid) else $error("result dropped");
  a_count_mono: assert property (@(posedge clk) disable iff (rst)
    m_fire |=> count_acc == $past(count_acc) || (s_fire && in_op == OP_CLEAR))
    else $error("count moved");
endmodule
